// File: rtl/zhang_suen_thinning_top_defines.svh
// assertion macros shared by the thinning block
// no dependencies; included by modules that carry assertions
`ifndef ZHANG_SUEN_THINNING_TOP_DEFINES_SVH
`define ZHANG_SUEN_THINNING_TOP_DEFINES_SVH

// same-cycle implication
`define ZST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ZST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/zst_pkg.sv
// shared type and row width for the thinning block
// no dependencies
`timescale 1ns / 1ps
package zst_pkg;

    localparam int ROW_BITS = 64;

    // 3x3 neighbourhood of one column cell, bit 0 west, bit 2 east
    typedef struct packed {
        logic [2:0] up;
        logic [2:0] cur;
        logic [2:0] down;
    } zst_win_t;

endpackage

// File: rtl/zst_cell.sv
// one column cell: decides whether its centre pixel is deleted
// depends on zst_pkg
`timescale 1ns / 1ps
module zst_cell
    import zst_pkg::*;
(
    input  zst_win_t win,
    input  logic     phase,
    input  logic     en,
    output logic     del
);

    logic [7:0] nb;
    logic [3:0] b_cnt;
    logic [3:0] a_cnt;
    logic       n, e, s, w;
    logic       rule_ok;

    // neighbours in order north, ne, east, se, south, sw, west, nw
    assign nb = {win.up[0], win.cur[0], win.down[0], win.down[1],
                 win.down[2], win.cur[2], win.up[2], win.up[1]};
    assign n = win.up[1];
    assign e = win.cur[2];
    assign s = win.down[1];
    assign w = win.cur[0];

    always_comb
    begin
        b_cnt = 4'($countones(nb));
        a_cnt = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (!nb[k] && nb[(k + 1) % 8])
            begin
                a_cnt = a_cnt + 4'd1;
            end
        end
    end

    assign rule_ok = phase ? (!(n & e & w) && !(n & s & w))
                           : (!(n & e & s) && !(e & s & w));

    assign del = en && win.cur[1] && (b_cnt >= 4'd2) && (b_cnt <= 4'd6)
                 && (a_cnt == 4'd1) && rule_ok;

endmodule

// File: rtl/zhang_suen_thinning_top.sv
// zhang-suen thinning block, top level with row store and sequencer
// depends on zst_pkg, zst_cell and zhang_suen_thinning_top_defines.svh
//
// usage:
//   rows enter on the in channel (row_bits, in_valid/in_ready), one beat per
//   row, bit i is column i; bits at or above image_width are dropped.
//   once image_height rows are in, the image is thinned in place and every
//   row leaves on the out channel (thin_row_bits, last_row on the final one).
//   loading accepts one row per cycle. each subiteration sweeps the stored
//   rows through a row of column cells after priming the window, its pace
//   limited by the single read port of the row store; the number of
//   subiterations depends on the image. each output row is read from the
//   store and then loaded into the output register once that is free.
//   the config port (cfg_we, cfg_index, cfg_data) sets width and height and
//   restarts loading; write it only while idle.
//   a stalled receiver holds the output register and the sequencer waits;
//   the next image may start loading while the last row is still held.
//   reset sets width MAX_WIDTH, height min(MAX_HEIGHT, 64), empties row count.
`timescale 1ns / 1ps
`include "zhang_suen_thinning_top_defines.svh"
module zhang_suen_thinning_top
    import zst_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [6:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ROW_BITS-1:0] row_bits,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ROW_BITS-1:0] thin_row_bits,
    output logic                last_row
);

    localparam int W    = MAX_WIDTH;
    localparam int HCAP = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;
    localparam int AW   = $clog2(HCAP);

    localparam logic       REG_WIDTH  = 1'b0;
    localparam logic       REG_HEIGHT = 1'b1;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_P0   = 3'd1;
    localparam logic [2:0] S_P1   = 3'd2;
    localparam logic [2:0] S_P2   = 3'd3;
    localparam logic [2:0] S_P3   = 3'd4;
    localparam logic [2:0] S_COMP = 3'd5;
    localparam logic [2:0] S_ORD  = 3'd6;
    localparam logic [2:0] S_OLD  = 3'd7;

    logic [2:0]   state_reg, state_next;
    logic [6:0]   width_reg, width_next;
    logic [6:0]   height_reg, height_next;
    logic [6:0]   rows_loaded_reg, rows_loaded_next;
    logic [6:0]   row_idx_reg, row_idx_next;
    logic         phase_reg, phase_next;
    logic         any_reg, any_next;
    logic [W-1:0] up_reg, up_next;
    logic [W-1:0] cur_reg, cur_next;
    logic [W-1:0] down_reg, down_next;
    logic [W-1:0] out_data_reg, out_data_next;
    logic         out_valid_reg, out_valid_next;
    logic         out_last_reg, out_last_next;
    logic [W-1:0] rd_data_reg;

    logic [W-1:0] mem [HCAP];
    logic         mem_we, mem_re;
    logic [6:0]   mem_waddr, mem_raddr;
    logic [W-1:0] mem_wdata;

    logic [W-1:0] width_mask;
    logic [W-1:0] del;
    logic         in_acc, out_free;
    logic [6:0]   cfg_clamp_w, cfg_clamp_h;

    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            width_mask[i] = (7'(i) < width_reg);
        end
    end

    assign del[0]   = 1'b0;
    assign del[W-1] = 1'b0;

    genvar c;
    generate
        for (c = 1; c < W - 1; c++)
        begin : g_col
            zst_win_t win;
            assign win.up   = up_reg[c+1:c-1];
            assign win.cur  = cur_reg[c+1:c-1];
            assign win.down = down_reg[c+1:c-1];
            zst_cell u_cell (
                .win   (win),
                .phase (phase_reg),
                .en    (7'(c + 1) < width_reg),
                .del   (del[c])
            );
        end
    endgenerate

    always_comb
    begin
        cfg_clamp_w = (cfg_data < 7'd3) ? 7'd3
                    : (cfg_data > 7'(W)) ? 7'(W) : cfg_data;
        cfg_clamp_h = (cfg_data < 7'd3) ? 7'd3
                    : (cfg_data > 7'(HCAP)) ? 7'(HCAP) : cfg_data;
    end

    assign in_ready  = (state_reg == S_LOAD);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next       = state_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        rows_loaded_next = rows_loaded_reg;
        row_idx_next     = row_idx_reg;
        phase_next       = phase_reg;
        any_next         = any_reg;
        up_next          = up_reg;
        cur_next         = cur_reg;
        down_next        = down_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_last_next    = out_last_reg;
        mem_we           = 1'b0;
        mem_waddr        = rows_loaded_reg;
        mem_wdata        = row_bits[W-1:0] & width_mask;
        mem_re           = 1'b0;
        mem_raddr        = '0;

        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    mem_we = 1'b1;
                    if (rows_loaded_reg == height_reg - 7'd1)
                    begin
                        rows_loaded_next = '0;
                        phase_next       = 1'b0;
                        any_next         = 1'b0;
                        state_next       = S_P0;
                    end
                    else
                    begin
                        rows_loaded_next = rows_loaded_reg + 7'd1;
                    end
                end
            end
            S_P0:
            begin
                mem_re     = 1'b1;
                mem_raddr  = 7'd0;
                state_next = S_P1;
            end
            S_P1:
            begin
                up_next    = rd_data_reg;
                mem_re     = 1'b1;
                mem_raddr  = 7'd1;
                state_next = S_P2;
            end
            S_P2:
            begin
                cur_next     = rd_data_reg;
                mem_re       = 1'b1;
                mem_raddr    = 7'd2;
                row_idx_next = 7'd1;
                state_next   = S_P3;
            end
            S_P3:
            begin
                down_next  = rd_data_reg;
                state_next = S_COMP;
            end
            S_COMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = row_idx_reg;
                mem_wdata = cur_reg & ~del;
                up_next   = cur_reg;
                cur_next  = down_reg;
                any_next  = any_reg || (|del);
                if (row_idx_reg == height_reg - 7'd2)
                begin
                    if (any_next)
                    begin
                        phase_next = !phase_reg;
                        any_next   = 1'b0;
                        state_next = S_P0;
                    end
                    else
                    begin
                        phase_next   = 1'b0;
                        any_next     = 1'b0;
                        row_idx_next = '0;
                        state_next   = S_ORD;
                    end
                end
                else
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = row_idx_reg + 7'd2;
                    row_idx_next = row_idx_reg + 7'd1;
                    state_next   = S_P3;
                end
            end
            S_ORD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = row_idx_reg;
                state_next = S_OLD;
            end
            S_OLD:
            begin
                if (out_free)
                begin
                    out_data_next  = rd_data_reg;
                    out_valid_next = 1'b1;
                    out_last_next  = (row_idx_reg == height_reg - 7'd1);
                    if (out_last_next)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        row_idx_next = row_idx_reg + 7'd1;
                        state_next   = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (cfg_we)
        begin
            rows_loaded_next = '0;
            case (cfg_index)
                REG_WIDTH:  width_next  = cfg_clamp_w;
                REG_HEIGHT: height_next = cfg_clamp_h;
                default:    width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            width_reg       <= 7'(W);
            height_reg      <= 7'(HCAP);
            rows_loaded_reg <= '0;
            row_idx_reg     <= '0;
            phase_reg       <= 1'b0;
            any_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            rows_loaded_reg <= rows_loaded_next;
            row_idx_reg     <= row_idx_next;
            phase_reg       <= phase_next;
            any_reg         <= any_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        up_reg       <= up_next;
        cur_reg      <= cur_next;
        down_reg     <= down_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // row store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr[AW-1:0]] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr[AW-1:0]];
        end
    end

    assign out_valid     = out_valid_reg;
    assign thin_row_bits = ROW_BITS'(out_data_reg);
    assign last_row      = out_last_reg;

    `ZST_ASSERT_NOW(a_rows_below_height, state_reg == S_LOAD,
        rows_loaded_reg < height_reg, "row count reached image height")
    `ZST_ASSERT_NEXT(a_full_image_starts,
        in_acc && !cfg_we && rows_loaded_reg == height_reg - 7'd1,
        state_reg == S_P0, "complete image did not start thinning")
    `ZST_ASSERT_NOW(a_del_foreground, state_reg == S_COMP,
        (del & ~cur_reg) == '0, "deletion of a background pixel")
    `ZST_ASSERT_NEXT(a_out_hold, out_valid_reg && !out_ready,
        out_valid_reg && $stable(out_data_reg) && $stable(out_last_reg),
        "stalled out beat changed")

endmodule
